FILE: rtl/pfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared widths, payload types and prescale tables for the PWM setup block.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int CLK_W      = 25;
  localparam int FREQ_W     = 18;
  localparam int DUTY_W     = 7;
  localparam int RELOAD_W   = 16;
  localparam int CNT_W      = 25;
  localparam int DIVISOR_W  = 14;
  localparam int RECIP_W    = 29;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W     = CNT_W + DUTY_W;

  localparam int DIRECT_PERIOD_LIMIT_DEFAULT = 32768;

  localparam logic [CLK_W-1:0]     SYS_CLOCK_RESET = 25'd27000000;
  localparam logic [CNT_W-1:0]     WIDE_LIMIT      = 25'd32767;
  localparam logic [DUTY_W-1:0]    PCT_FULL        = 7'd100;
  localparam logic [DIVISOR_W-1:0] PCT_DIVISOR     = 14'd100;
  localparam logic [RECIP_W-1:0]   PCT_RECIP       = 29'd42949672;
  localparam logic [FREQ_W-1:0]    BAND_HI         = 18'd1000;
  localparam logic [FREQ_W-1:0]    BAND_MID        = 18'd100;
  localparam logic [FREQ_W-1:0]    BAND_LO         = 18'd10;
  localparam logic [FREQ_W-1:0]    BAND_ONE        = 18'd1;

  typedef enum logic [1:0] {
    PRE_10000 = 2'd0,
    PRE_1000  = 2'd1,
    PRE_100   = 2'd2,
    PRE_10    = 2'd3
  } pre_code_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_hz;
    logic [DUTY_W-1:0] duty_percent;
  } request_t;

  typedef struct packed {
    logic                output_enabled;
    logic                idle_level;
    logic                clock_from_timer;
    logic                timer_written;
    logic [RELOAD_W-1:0] timer_reload;
    logic [CNT_W-1:0]    period_count;
    logic [CNT_W-1:0]    compare_count;
    logic                period_too_wide;
  } result_t;

  function automatic pre_code_t band_code(input logic [FREQ_W-1:0] f);
    pre_code_t code;
    priority if (f > BAND_MID && f <= BAND_HI) begin
      code = PRE_10000;
    end else if (f > BAND_LO && f <= BAND_MID) begin
      code = PRE_1000;
    end else if (f > BAND_ONE && f <= BAND_LO) begin
      code = PRE_100;
    end else begin
      code = PRE_10;
    end
    return code;
  endfunction

  function automatic logic [DIVISOR_W-1:0] pre_divisor(input pre_code_t code);
    logic [DIVISOR_W-1:0] d;
    unique case (code)
      PRE_10000: d = 14'd10000;
      PRE_1000:  d = 14'd1000;
      PRE_100:   d = 14'd100;
      PRE_10:    d = 14'd10;
      default:   d = 14'd10;
    endcase
    return d;
  endfunction

  // floor(2^32 / prescale)
  function automatic logic [RECIP_W-1:0] pre_recip(input pre_code_t code);
    logic [RECIP_W-1:0] r;
    unique case (code)
      PRE_10000: r = 29'd429496;
      PRE_1000:  r = 29'd4294967;
      PRE_100:   r = 29'd42949672;
      PRE_10:    r = 29'd429496729;
      default:   r = 29'd429496729;
    endcase
    return r;
  endfunction

  function automatic logic [RELOAD_W-1:0] pre_reload(input pre_code_t code);
    logic [RELOAD_W-1:0] v;
    unique case (code)
      PRE_10000: v = 16'd55536;
      PRE_1000:  v = 16'd64536;
      PRE_100:   v = 16'd65436;
      PRE_10:    v = 16'd65526;
      default:   v = 16'd65526;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/pfd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module pfd_div import pfd_pkg::*; #(
  parameter int NW = CLK_W,
  parameter int DW = FREQ_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] quotient,
  output logic [SW-1:0] out_side
);

  logic [NW:0]   vld;
  logic [DW-1:0] rem  [NW+1];
  logic [NW-1:0] qn   [NW+1];
  logic [DW-1:0] dvs  [NW+1];
  logic [SW-1:0] side [NW+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign qn[0]   = dividend;
  assign dvs[0]  = divisor;
  assign side[0] = in_side;

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem[k], qn[k][NW-1]};
    assign diff  = trial - {1'b0, dvs[k]};
    assign ge    = (trial >= {1'b0, dvs[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      qn[k+1]   <= {qn[k][NW-2:0], ge};
      dvs[k+1]  <= dvs[k];
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[NW];
  assign quotient  = qn[NW];
  assign out_side  = side[NW];

endmodule

FILE: rtl/pfd_cdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_cdiv
// Three-stage divide by a small constant: reciprocal multiply, back multiply,
// one-step correction. Valid for dividends below 2^32.
// ----------------------------------------------------------------------------
module pfd_cdiv import pfd_pkg::*; #(
  parameter int XW = PROD_W,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [XW-1:0]        x,
  input  logic [DIVISOR_W-1:0] divisor,
  input  logic [RECIP_W-1:0]   recip,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic [XW-1:0]        q,
  output logic [SW-1:0]        out_side
);

  logic [XW+RECIP_W-1:0]   prod;
  logic [XW+DIVISOR_W-1:0] back;
  logic [XW-1:0]           resid;

  logic                 s1_valid, s2_valid, s3_valid;
  logic [XW-1:0]        s1_x, s1_est, s2_x, s2_est, s2_back, s3_q;
  logic [DIVISOR_W-1:0] s1_div, s2_div;
  logic [SW-1:0]        s1_side, s2_side, s3_side;

  assign prod  = (XW+RECIP_W)'(x) * (XW+RECIP_W)'(recip);
  assign back  = (XW+DIVISOR_W)'(s1_est) * (XW+DIVISOR_W)'(s1_div);
  assign resid = s2_x - s2_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_x    <= x;
    s1_est  <= XW'(prod >> RECIP_SHIFT);
    s1_div  <= divisor;
    s1_side <= in_side;

    s2_x    <= s1_x;
    s2_est  <= s1_est;
    s2_back <= back[XW-1:0];
    s2_div  <= s1_div;
    s2_side <= s1_side;

    // estimate is low by at most one
    s3_q    <= (resid >= XW'(s2_div)) ? s2_est + XW'(1) : s2_est;
    s3_side <= s2_side;
  end

  assign out_valid = s3_valid;
  assign q         = s3_q;
  assign out_side  = s3_side;

endmodule

FILE: rtl/pwm_frequency_duty_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_frequency_duty_setup
// PWM period and compare settings from a frequency and duty request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request and raise start; a beat is taken at each
//   rising edge with start high and busy low. busy is high only in reset.
//   Result channel: done is high for one cycle with result valid; the
//   receiver cannot stall and must take the beat in that cycle.
//   Config channel: cfg_data is written to the system clock register on
//   cfg_valid with cfg_ready (always high). Write only while idle.
// Throughput: one request per cycle, every cycle outside reset.
// An accepted request passes 25 stages of the bit-per-stage period divider,
//   a band stage, three stages of the prescale divide, a duty multiply stage,
//   three stages of the percent divide and the output register, which raises
//   done.
// Reset: synchronous; flushes all requests in flight and loads the system
//   clock register with 27 MHz.
// ----------------------------------------------------------------------------
module pwm_frequency_duty_setup import pfd_pkg::*; #(
  parameter int DIRECT_PERIOD_LIMIT = DIRECT_PERIOD_LIMIT_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  request_t         request,
  output logic             done,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CLK_W-1:0] cfg_data
);

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DIRECT_PERIOD_LIMIT);

  typedef struct packed {
    request_t         req;
    logic             wide;
    pre_code_t        code;
    logic [CNT_W-1:0] period;
  } side_t;

  logic [CLK_W-1:0] sys_clock_hz;

  logic             dv_valid;
  logic [CNT_W-1:0] dv_q;
  request_t         dv_req;

  logic             a_valid;
  side_t            a_side;

  logic             c1_valid;
  logic [CNT_W-1:0] c1_q;
  side_t            c1_side;
  logic [CNT_W-1:0] sel_period;

  logic              b_valid;
  logic [PROD_W-1:0] b_product;
  side_t             b_side;

  logic              c2_valid;
  logic [PROD_W-1:0] c2_q;
  side_t             c2_side;

  logic    off, full;
  result_t result_next;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_clock_hz <= SYS_CLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sys_clock_hz <= cfg_data;
    end
  end

  pfd_div #(
    .NW (CLK_W),
    .DW (FREQ_W),
    .SW ($bits(request_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .dividend  (sys_clock_hz),
    .divisor   (request.freq_hz),
    .in_side   (request),
    .out_valid (dv_valid),
    .quotient  (dv_q),
    .out_side  (dv_req)
  );

  // band select; (clk / pre) / f equals (clk / f) / pre
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_side.req    <= dv_req;
    a_side.wide   <= (dv_q >= LIMIT);
    a_side.code   <= band_code(dv_req.freq_hz);
    a_side.period <= dv_q;
  end

  pfd_cdiv #(
    .XW (CNT_W),
    .SW ($bits(side_t))
  ) u_pre_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .x         (a_side.period),
    .divisor   (pre_divisor(a_side.code)),
    .recip     (pre_recip(a_side.code)),
    .in_side   (a_side),
    .out_valid (c1_valid),
    .q         (c1_q),
    .out_side  (c1_side)
  );

  assign sel_period = c1_side.wide ? c1_q : c1_side.period;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_product <= PROD_W'(sel_period) *
                 PROD_W'(PCT_FULL - c1_side.req.duty_percent);
    b_side    <= '{req: c1_side.req, wide: c1_side.wide, code: c1_side.code,
                   period: sel_period};
  end

  pfd_cdiv #(
    .XW (PROD_W),
    .SW ($bits(side_t))
  ) u_pct_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .x         (b_product),
    .divisor   (PCT_DIVISOR),
    .recip     (PCT_RECIP),
    .in_side   (b_side),
    .out_valid (c2_valid),
    .q         (c2_q),
    .out_side  (c2_side)
  );

  assign off  = (c2_side.req.freq_hz == '0) || (c2_side.req.duty_percent == '0);
  assign full = (c2_side.req.duty_percent >= PCT_FULL);

  always_comb begin
    result_next = '0;
    if (off) begin
      result_next.idle_level = 1'b0;
    end else if (full) begin
      result_next.idle_level = 1'b1;
    end else begin
      result_next.output_enabled   = 1'b1;
      result_next.clock_from_timer = c2_side.wide;
      result_next.timer_written    = c2_side.wide;
      result_next.timer_reload     = c2_side.wide ? pre_reload(c2_side.code) : '0;
      result_next.period_count     = c2_side.period;
      result_next.compare_count    = c2_q[CNT_W-1:0];
      result_next.period_too_wide  = (c2_side.period > WIDE_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_off_quiet: assert property (@(posedge clk) disable iff (rst)
    done && !result.output_enabled |->
      result.period_count == '0 && result.compare_count == '0 &&
      !result.clock_from_timer && !result.timer_written)
    else $error("disabled result carries settings");

  a_level_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.output_enabled && result.idle_level))
    else $error("idle level set on enabled output");

  a_compare_le: assert property (@(posedge clk) disable iff (rst)
    done && result.output_enabled |-> result.compare_count <= result.period_count)
    else $error("compare beyond period");

  a_timer_reload: assert property (@(posedge clk) disable iff (rst)
    done && result.clock_from_timer |->
      result.timer_written && result.timer_reload != '0)
    else $error("timer clock without reload");

endmodule
